>>> rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int VAL_W          = 32;
    localparam int LIST_NUM_W     = 3;
    localparam int LISTS_DEF      = 8;
    localparam int LIST_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_OUT    = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

endpackage

>>> rtl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges LISTS sorted FIFO lists held in one value memory, lowest value first.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A load transfer (tuser = 0) reads the
// list's pointer entry, writes value and pointers back, and posts the
// result. A pull transfer (tuser = 1) scans the lists, pops the lowest head
// and posts it: the scan walks the pointer memory one list per cycle and
// reads each head from the value memory in the cycle after, so the scan
// length is set by the single read port of each memory. The scan drains its
// pipeline earlier when the top lists are empty. A pull with every list
// empty, or a load naming a list at or above LISTS, goes straight to posting
// its result. The result sits in an output register; while it waits for
// m_axis_tready the next item is still accepted and worked on, and only the
// move of that item's result into the output register waits.
// Values are signed 32 bit; equal values are taken from the lower list.
// ----------------------------------------------------------------------------
module k_way_sorted_merge import kwm_pkg::*; #(
    parameter int LISTS      = LISTS_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [2:0] list_number, [34:3] item_value
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] merged_value, [34:32] source_list
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // final_flag
);

    localparam int LW  = $clog2(LISTS);
    localparam int PW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW  = $clog2(LIST_DEPTH + 1);
    localparam int MW  = FW + 2 * PW;                 // {fill, wr, rd}
    localparam int SW  = LW + PW;
    localparam int SD  = LISTS * (2 ** PW);
    localparam int TW  = $clog2(LISTS * LIST_DEPTH + 1);
    localparam int SCW = $clog2(LISTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_POP,
        S_FIN
    } t_state;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] pos);
        return (pos == PW'(LIST_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    // control
    t_state           r_state;
    logic [LW-1:0]    r_li;
    logic [SCW-1:0]   r_scan;
    logic             r_s1_vld;
    logic [LW-1:0]    r_s1_idx;
    logic             r_s2_vld;
    logic [LW-1:0]    r_s2_idx;
    logic [MW-1:0]    r_s2_meta;
    logic [LISTS-1:0] r_nonempty;
    logic [LISTS-1:0] r_meta_vld;
    logic [TW-1:0]    r_total;
    logic             r_out_vld;

    // load value captured at acceptance
    logic [VAL_W-1:0] r_ld_val;

    // result payload
    t_status          r_res_status;
    logic [VAL_W-1:0] r_res_val;
    logic [2:0]       r_res_src;
    logic             r_res_fin;
    t_status          r_out_status;
    logic [VAL_W-1:0] r_out_val;
    logic [2:0]       r_out_src;
    logic             r_out_fin;

    // memories
    logic [MW-1:0]    r_meta_mem [LISTS];
    logic [MW-1:0]    r_meta_q;
    logic             r_meta_qv;
    logic [VAL_W-1:0] r_store_mem [SD];
    logic [VAL_W-1:0] r_store_q;

    // memory ports
    logic [LW-1:0]    meta_raddr;
    logic             meta_we;
    logic [LW-1:0]    meta_waddr;
    logic [MW-1:0]    meta_wdata;
    logic [SW-1:0]    store_raddr;
    logic             store_we;
    logic [SW-1:0]    store_waddr;

    // input fields
    logic                  in_acc;
    logic                  in_kind;
    logic [LIST_NUM_W-1:0] in_list;
    logic [VAL_W-1:0]      in_val;
    logic                  in_list_ok;

    // pointer entry as read, unwritten entries read as zero
    logic [MW-1:0] meta_eff;
    logic [PW-1:0] m_rd;
    logic [PW-1:0] m_wr;
    logic [FW-1:0] m_fill;
    logic          load_full;

    // best head of the scan
    logic [LW-1:0]    best_idx;
    logic [VAL_W-1:0] best_val;
    logic [MW-1:0]    best_meta;
    logic [PW-1:0]    b_rd;
    logic [PW-1:0]    b_wr;
    logic [FW-1:0]    b_fill;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_list       = s_axis_tdata[2:0];
    assign in_val        = s_axis_tdata[34:3];
    assign in_list_ok    = 32'(in_list) < 32'(LISTS);

    assign meta_eff  = r_meta_qv ? r_meta_q : '0;
    assign m_rd      = meta_eff[PW-1:0];
    assign m_wr      = meta_eff[2*PW-1:PW];
    assign m_fill    = meta_eff[MW-1:2*PW];
    assign load_full = (m_fill >= FW'(LIST_DEPTH));

    assign b_rd   = best_meta[PW-1:0];
    assign b_wr   = best_meta[2*PW-1:PW];
    assign b_fill = best_meta[MW-1:2*PW];

    // Pick the memory addresses for this cycle; writes happen only in the
    // load write-back and in the pop.
    always_comb begin
        meta_raddr  = r_li;
        meta_we     = 1'b0;
        meta_waddr  = r_li;
        meta_wdata  = '0;
        store_raddr = {r_s1_idx, m_rd};
        store_we    = 1'b0;
        store_waddr = {r_li, m_wr};
        unique case (r_state)
            S_IDLE: begin
                meta_raddr = LW'(in_list);
            end
            S_LOAD: begin
                if (!load_full) begin
                    store_we   = 1'b1;
                    meta_we    = 1'b1;
                    meta_wdata = {m_fill + 1'b1, next_slot(m_wr), m_rd};
                end
            end
            S_SCAN: begin
                meta_raddr = r_scan[LW-1:0];
            end
            S_POP: begin
                meta_we    = 1'b1;
                meta_waddr = best_idx;
                meta_wdata = {b_fill - 1'b1, b_wr, next_slot(b_rd)};
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // pointer memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= r_meta_mem[meta_raddr];
    end

    // value memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store_mem[store_waddr] <= r_ld_val;
        end
        r_store_q <= r_store_mem[store_raddr];
    end

    kwm_head_select #(
        .LISTS  (LISTS),
        .META_W (MW)
    ) u_head_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (in_acc && in_kind),
        .i_cand_vld  (r_s2_vld),
        .i_cand_idx  (r_s2_idx),
        .i_cand_val  (r_store_q),
        .i_cand_meta (r_s2_meta),
        .o_best_idx  (best_idx),
        .o_best_val  (best_val),
        .o_best_meta (best_meta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan     <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_nonempty <= '0;
            r_meta_vld <= '0;
            r_meta_qv  <= 1'b0;
            r_total    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_meta_qv <= r_meta_vld[meta_raddr];

            // drop the result once the downstream side takes it; in S_FIN the
            // reload below decides the valid bit
            if (r_out_vld && m_axis_tready && (r_state != S_FIN)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_li      <= LW'(in_list);
                        r_ld_val  <= in_val;
                        r_res_val <= '0;
                        r_res_src <= '0;
                        r_res_fin <= 1'b0;
                        r_scan    <= '0;
                        r_s1_vld  <= 1'b0;
                        r_s2_vld  <= 1'b0;
                        if (!in_kind) begin
                            if (in_list_ok) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_FIN;
                            end
                        end else if (r_total == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_LOAD: begin
                    if (load_full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_res_status       <= ST_STORED;
                        r_meta_vld[r_li]   <= 1'b1;
                        r_nonempty[r_li]   <= 1'b1;
                        r_total            <= r_total + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_SCAN: begin
                    // stage 0: issue pointer read, stage 1: issue head read,
                    // stage 2: compare in the head selector
                    if (r_scan < SCW'(LISTS)) begin
                        r_s1_vld <= r_nonempty[r_scan[LW-1:0]];
                        r_s1_idx <= r_scan[LW-1:0];
                        r_scan   <= r_scan + 1'b1;
                    end else begin
                        r_s1_vld <= 1'b0;
                    end
                    r_s2_vld  <= r_s1_vld;
                    r_s2_idx  <= r_s1_idx;
                    r_s2_meta <= meta_eff;
                    if (r_scan == SCW'(LISTS) && !r_s1_vld && !r_s2_vld) begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_meta_vld[best_idx] <= 1'b1;
                    if (b_fill == FW'(1)) begin
                        r_nonempty[best_idx] <= 1'b0;
                    end
                    r_total      <= r_total - 1'b1;
                    r_res_status <= ST_OUT;
                    r_res_val    <= best_val;
                    r_res_src    <= 3'(best_idx);
                    r_res_fin    <= (r_total == TW'(1));
                    r_state      <= S_FIN;
                end
                S_FIN: begin
                    // hold the result until the output register is free
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_val    <= r_res_val;
                        r_out_src    <= r_res_src;
                        r_out_fin    <= r_res_fin;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_src, r_out_val};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_fin;

endmodule

>>> rtl/kwm_head_select.sv
// ----------------------------------------------------------------------------
// kwm_head_select
// Running minimum over the list heads streamed in during a pull scan.
// ----------------------------------------------------------------------------
module kwm_head_select import kwm_pkg::*; #(
    parameter int LISTS  = LISTS_DEF,
    parameter int META_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_cand_vld,
    input  logic [$clog2(LISTS)-1:0] i_cand_idx,
    input  logic [VAL_W-1:0]         i_cand_val,
    input  logic [META_W-1:0]        i_cand_meta,
    output logic [$clog2(LISTS)-1:0] o_best_idx,
    output logic [VAL_W-1:0]         o_best_val,
    output logic [META_W-1:0]        o_best_meta
);

    logic                     r_found;
    logic [$clog2(LISTS)-1:0] r_best_idx;
    logic [VAL_W-1:0]         r_best_val;
    logic [META_W-1:0]        r_best_meta;
    logic                     take;

    // strict less keeps the lower list on equal values
    assign take = i_cand_vld && (!r_found || ($signed(i_cand_val) < $signed(r_best_val)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            priority if (i_clear) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found     <= 1'b1;
                r_best_idx  <= i_cand_idx;
                r_best_val  <= i_cand_val;
                r_best_meta <= i_cand_meta;
            end
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_val  = r_best_val;
    assign o_best_meta = r_best_meta;

endmodule
